// ----- rtl/assert_macros.svh -----
// assertion helpers for the rgba blit compositor
// used by the top level only; expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RBC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define RBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/rbc_pkg.sv -----
// shared types and constants of the rgba blit compositor
// no dependencies
package rbc_pkg;

  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned PIX_W     = 32;
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned W_W       = 16;  // alpha weight, 0..65025
  localparam int unsigned NUM_W     = 24;  // blend numerator, < 2**24

  localparam logic [W_W-1:0] ALPHA_SCALE = 16'd65025;
  // floor(num/65025) estimate: (num * 1032) >> 26, low by at most one
  localparam int unsigned RECIP_SHIFT = 26;

  localparam logic [1:0] REG_BLEND_MODE   = 2'd0;
  localparam logic [1:0] REG_GLOBAL_ALPHA = 2'd1;
  localparam logic [1:0] REG_TINT_COLOR   = 2'd2;

  typedef enum logic [1:0] {
    MODE_COPY  = 2'd0,
    MODE_ALPHA = 2'd1,
    MODE_TINT  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [CHAN_W-1:0] src;
    logic [CHAN_W-1:0] blend;
    logic [CHAN_W-1:0] tint;
  } lane_out_t;

endpackage

// ----- rtl/rbc_in_if.sv -----
// pixel input channel: source and destination pixels
// no dependencies
interface rbc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_pixel;
  logic [31:0] dst_pixel;
  modport source(output valid, src_pixel, dst_pixel, input ready);
  modport sink(input valid, src_pixel, dst_pixel, output ready);
endinterface

// ----- rtl/rbc_out_if.sv -----
// composited pixel output channel
// no dependencies
interface rbc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_pixel;
  logic        write_enable;
  modport source(output valid, out_pixel, write_enable, input ready);
  modport sink(input valid, out_pixel, write_enable, output ready);
endinterface

// ----- rtl/rbc_cfg_if.sv -----
// register write channel
// no dependencies
interface rbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/rbc_lane.sv -----
// one color channel of the compositor: blend and tint pipeline
// depends on rbc_pkg
module rbc_lane (
  input  logic                     clk,
  input  logic                     en,
  input  logic [7:0]               src_chan,
  input  logic [7:0]               dst_chan,
  input  logic [7:0]               src_alpha,
  input  logic [7:0]               global_alpha,
  input  logic [7:0]               tint_chan,
  output rbc_pkg::lane_out_t       res
);
  import rbc_pkg::*;

  // stage 1
  logic [W_W-1:0]    w_r;
  logic [W_W-1:0]    tprod_r;
  logic [CHAN_W-1:0] src1_r, dst1_r;
  // stage 2
  logic [NUM_W-1:0]  num2_r;
  logic [CHAN_W-1:0] tint2_r, src2_r;
  // stage 3
  logic [NUM_W-1:0]  num3_r;
  logic [CHAN_W-1:0] qe3_r, tint3_r, src3_r;

  logic [NUM_W:0]    num_nxt;
  logic [W_W:0]      tsum;
  logic [34:0]       recip_prod;
  logic [NUM_W-1:0]  qmul;
  logic [NUM_W-1:0]  rem;

  always_comb begin
    num_nxt = {1'b0, 8'd0, src1_r} * {9'd0, w_r}
            + {1'b0, 8'd0, dst1_r} * {9'd0, ALPHA_SCALE - w_r};
    // x/255 for a product of two bytes
    tsum = {1'b0, tprod_r} + {9'd0, tprod_r[15:8]} + 17'd1;
    recip_prod = ({11'd0, num2_r} << 10) + ({11'd0, num2_r} << 3);
    // q * 65025 = q * 65536 - q * 512 + q
    qmul = {qe3_r, 16'd0} - {7'd0, qe3_r, 9'd0} + {16'd0, qe3_r};
    rem  = num3_r - qmul;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r     <= {8'd0, src_alpha} * {8'd0, global_alpha};
      tprod_r <= {8'd0, src_chan} * {8'd0, tint_chan};
      src1_r  <= src_chan;
      dst1_r  <= dst_chan;

      num2_r  <= num_nxt[NUM_W-1:0];
      tint2_r <= tsum[15:8];
      src2_r  <= src1_r;

      num3_r  <= num2_r;
      qe3_r   <= recip_prod[RECIP_SHIFT+7:RECIP_SHIFT];
      tint3_r <= tint2_r;
      src3_r  <= src2_r;
    end
  end

  // correct the low-by-one estimate
  always_comb begin
    res.src   = src3_r;
    res.tint  = tint3_r;
    res.blend = qe3_r + ((rem >= {8'd0, ALPHA_SCALE}) ? 8'd1 : 8'd0);
  end

endmodule

// ----- rtl/rbc_merge.sv -----
// merge stage: picks the mode result from the lanes, output register
// depends on rbc_pkg and rbc_out_if
module rbc_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_in,
  input  rbc_pkg::lane_out_t lanes [rbc_pkg::NUM_LANES],
  input  logic [1:0]         blend_mode,
  output logic               adv,
  rbc_out_if.source          out_ch
);
  import rbc_pkg::*;

  logic             out_valid_r;
  logic [PIX_W-1:0] pix_r, pix_nxt;
  logic             we_r, we_nxt;
  logic [PIX_W-1:0] src_pix, blend_pix, tint_pix;

  assign adv = !out_valid_r || out_ch.ready;

  always_comb begin
    src_pix   = {lanes[3].src, lanes[2].src, lanes[1].src, lanes[0].src};
    blend_pix = {8'hff, lanes[2].blend, lanes[1].blend, lanes[0].blend};
    tint_pix  = {lanes[3].tint, lanes[2].tint, lanes[1].tint, lanes[0].tint};
    pix_nxt   = '0;
    we_nxt    = 1'b0;
    case (blend_mode)
      MODE_COPY: begin
        pix_nxt = src_pix;
        we_nxt  = 1'b1;
      end
      MODE_ALPHA: begin
        pix_nxt = blend_pix;
        we_nxt  = 1'b1;
      end
      MODE_TINT: begin
        // fully transparent tint result is dropped
        if (lanes[3].tint != 8'd0) begin
          pix_nxt = tint_pix;
          we_nxt  = 1'b1;
        end
      end
      default: begin
        pix_nxt = '0;
        we_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_r <= pix_nxt;
      we_r  <= we_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_pixel    = pix_r;
  assign out_ch.write_enable = we_r;

endmodule

// ----- rtl/rgba_blit_pixel_compositor.sv -----
// top level of the rgba blit pixel compositor
// depends on rbc_pkg, the channel interfaces, rbc_lane, rbc_merge, assert_macros.svh
//
// usage
//   in_ch   pixel transactions: src_pixel and dst_pixel, rgba8 with red in 7:0
//   out_ch  result transactions: out_pixel and write_enable, one per input
//   cfg_ch  register writes: index 0 blend_mode, 1 global_alpha, 2 tint_color;
//           other indexes are ignored; always ready, write only while idle
// timing
//   one pixel per cycle sustained while out_ch does not stall; an input
//   transaction passes three lane stages and then the output register
//   before it shows on out_ch; the lane multiply stages set the depth
// reset
//   synchronous, active low; pipeline emptied, blend_mode copy,
//   global_alpha 255, tint_color all ones
// back-pressure
//   the whole pipeline holds while a result waits on out_ch; in_ch.ready
//   follows out_ch.ready then, and is high whenever the output register is
//   empty, so a stall costs no bubble once released
module rgba_blit_pixel_compositor (
  input  logic      clk,
  input  logic      rst_n,
  rbc_in_if.sink    in_ch,
  rbc_out_if.source out_ch,
  rbc_cfg_if.sink   cfg_ch
);
  import rbc_pkg::*;

`include "assert_macros.svh"

  // configuration registers
  logic [1:0]       blend_mode_r;
  logic [CHAN_W-1:0] global_alpha_r;
  logic [PIX_W-1:0] tint_color_r;

  // valid bits of the three lane stages
  logic [2:0]       vld_r;
  logic             adv;
  lane_out_t        lanes [NUM_LANES];

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_mode_r   <= MODE_COPY;
      global_alpha_r <= 8'hff;
      tint_color_r   <= 32'hffff_ffff;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_BLEND_MODE:   blend_mode_r   <= cfg_ch.data[1:0];
        REG_GLOBAL_ALPHA: global_alpha_r <= cfg_ch.data[7:0];
        REG_TINT_COLOR:   tint_color_r   <= cfg_ch.data;
        default: begin
          // unused index, no effect
        end
      endcase
    end
  end

  // valid travels with the data; everything shifts only on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[1:0], in_ch.valid};
    end
  end

  // one lane per channel; alpha lane blend result is unused (forced to 255)
  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    rbc_lane u_lane (
      .clk          (clk),
      .en           (adv),
      .src_chan     (in_ch.src_pixel[CHAN_W*k +: CHAN_W]),
      .dst_chan     (in_ch.dst_pixel[CHAN_W*k +: CHAN_W]),
      .src_alpha    (in_ch.src_pixel[31:24]),
      .global_alpha (global_alpha_r),
      .tint_chan    (tint_color_r[CHAN_W*k +: CHAN_W]),
      .res          (lanes[k])
    );
  end

  rbc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_in   (vld_r[2]),
    .lanes      (lanes),
    .blend_mode (blend_mode_r),
    .adv        (adv),
    .out_ch     (out_ch)
  );

  // checks
  `RBC_ASSERT_NEXT(a_accept_enters, in_ch.valid && in_ch.ready, vld_r[0])
  `RBC_ASSERT_SAME(a_alpha_opaque, out_ch.valid && blend_mode_r == MODE_ALPHA, out_ch.out_pixel[31:24] == 8'hff)
  `RBC_ASSERT_SAME(a_nowrite_zero, out_ch.valid && !out_ch.write_enable, out_ch.out_pixel == 32'd0)
  `RBC_ASSERT_SAME(a_copy_writes, out_ch.valid && blend_mode_r == MODE_COPY, out_ch.write_enable)

endmodule
